// ===== src/owms_pkg.sv =====
package owms_pkg;

  localparam logic [7:0] CMD_READ_ROM  = 8'h33;
  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_READ_MEM  = 8'hF0;
  localparam logic [7:0] CMD_WRITE_MEM = 8'h0F;

  localparam logic [63:0] ROM_ID_RESET = 64'hEF00_0065_ED8D_5209;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam int IMAGE_HEAD_LEN = 42;
  localparam int IMAGE_TAIL_INDEX = 129;
  localparam logic [7:0] IMAGE_TAIL_VALUE = 8'h17;
  localparam logic [7:0] IMAGE_FILL = 8'hFF;

  localparam logic [7:0] IMAGE_HEAD [IMAGE_HEAD_LEN] = '{
    8'h44, 8'h45, 8'h4c, 8'h4c, 8'h30, 8'h30, 8'h41, 8'h43, 8'h31, 8'h38, 8'h30, 8'h31,
    8'h39, 8'h35, 8'h30, 8'h39, 8'h32, 8'h43, 8'h4e, 8'h30, 8'h33, 8'h58, 8'h59, 8'h59,
    8'h38, 8'h43, 8'h48, 8'h32, 8'h30, 8'h30, 8'h30, 8'h33, 8'h47, 8'h43, 8'h34, 8'h34,
    8'h4b, 8'h41, 8'h30, 8'h31, 8'hd2, 8'h6e
  };

  localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CODE_RX   = 2'd1;
  localparam logic [1:0] PHASE_CODE_TX   = 2'd2;
  localparam logic [1:0] PHASE_CODE_CMD  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RX   = 4'b0010,
    PH_TX   = 4'b0100,
    PH_CMD  = 4'b1000
  } phase_t;

  typedef enum logic [7:0] {
    STEP_NONE       = 8'b0000_0001,
    STEP_COMMAND    = 8'b0000_0010,
    STEP_READ_ARGS  = 8'b0000_0100,
    STEP_WRITE_ARGS = 8'b0000_1000,
    STEP_SEND_ROM   = 8'b0001_0000,
    STEP_SEND_RCRC  = 8'b0010_0000,
    STEP_SEND_WCRC  = 8'b0100_0000,
    STEP_SEND_DATA  = 8'b1000_0000
  } step_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] rx_byte;
    logic       rx_byte_valid;
    logic       drive_zero;
    logic       presence;
  } result_t;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] image_byte(input logic [15:0] idx);
    logic [7:0] v;
    if (idx < 16'(IMAGE_HEAD_LEN)) begin
      v = IMAGE_HEAD[idx[5:0]];
    end else if (idx == 16'(IMAGE_TAIL_INDEX)) begin
      v = IMAGE_TAIL_VALUE;
    end else begin
      v = IMAGE_FILL;
    end
    return v;
  endfunction

endpackage

// ===== src/owms_ram.sv =====
module owms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 130,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/owms_core.sv =====
module owms_core import owms_pkg::*; #(
  parameter int MEM_BYTES = 130
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        cmd,
  input  logic        bus_bit,
  input  logic [63:0] rom_id,
  input  logic [7:0]  ram_rdata,
  output mem_req_t    mem_req,
  output result_t     res
);

  localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);

  phase_t      phase, phase_next;
  step_t       step, step_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        shift_from_ram, shift_from_ram_next;
  logic [7:0]  command_byte, command_byte_next;
  logic        selected, selected_next;
  logic [15:0] mem_address, mem_address_next;
  logic [7:0]  write_data, write_data_next;
  logic [7:0]  crc_byte, crc_byte_next;

  logic [7:0]  eff_shift;
  logic [7:0]  rx_shift;
  logic [7:0]  crc_rx;
  logic [7:0]  crc_cmd;
  logic [16:0] addr_inc;
  logic [7:0]  byte_index_inc;

  always_comb begin
    phase_next          = phase;
    step_next           = step;
    bit_index_next      = bit_index;
    byte_index_next     = byte_index;
    byte_count_next     = byte_count;
    shift_byte_next     = shift_byte;
    shift_from_ram_next = shift_from_ram;
    command_byte_next   = command_byte;
    selected_next       = selected;
    mem_address_next    = mem_address;
    write_data_next     = write_data;
    crc_byte_next       = crc_byte;
    mem_req             = '0;
    res                 = '0;

    eff_shift      = shift_from_ram ? ram_rdata : shift_byte;
    rx_shift       = eff_shift | (8'(bus_bit) << bit_index);
    crc_rx         = crc8_add(crc_byte, rx_shift);
    crc_cmd        = crc8_add(8'h00, rx_shift);
    addr_inc       = {1'b0, mem_address} + 17'd1;
    byte_index_inc = byte_index + 8'd1;

    if (fire) begin
      shift_byte_next     = eff_shift;
      shift_from_ram_next = 1'b0;
      if (!cmd) begin
        res.presence    = 1'b1;
        selected_next   = 1'b0;
        phase_next      = PH_CMD;
        step_next       = STEP_COMMAND;
        byte_count_next = 8'd1;
        byte_index_next = '0;
        bit_index_next  = '0;
        shift_byte_next = '0;
      end else if (phase == PH_RX || phase == PH_CMD) begin
        if (bit_index != 3'd7) begin
          bit_index_next  = bit_index + 3'd1;
          shift_byte_next = rx_shift;
        end else begin
          res.rx_byte_valid = 1'b1;
          res.rx_byte       = rx_shift;
          bit_index_next    = '0;
          shift_byte_next   = '0;
          byte_index_next   = '0;
          if (phase == PH_CMD) begin
            command_byte_next = rx_shift;
            phase_next        = PH_IDLE;
            step_next         = STEP_NONE;
            case (rx_shift)
              CMD_READ_ROM: begin
                byte_count_next = 8'd8;
                phase_next      = PH_TX;
                step_next       = STEP_SEND_ROM;
                shift_byte_next = rom_id[7:0];
              end
              CMD_SKIP_ROM: begin
                selected_next   = 1'b1;
                phase_next      = PH_CMD;
                step_next       = STEP_COMMAND;
                byte_count_next = 8'd1;
              end
              CMD_READ_MEM: begin
                if (selected) begin
                  phase_next      = PH_RX;
                  step_next       = STEP_READ_ARGS;
                  byte_count_next = 8'd2;
                  crc_byte_next   = crc_cmd;
                end
              end
              CMD_WRITE_MEM: begin
                if (selected) begin
                  phase_next      = PH_RX;
                  step_next       = STEP_WRITE_ARGS;
                  byte_count_next = 8'd3;
                  crc_byte_next   = crc_cmd;
                end
              end
              default: begin
                phase_next = PH_IDLE;
              end
            endcase
          end else begin
            if (byte_index == 8'd0) begin
              mem_address_next = {mem_address[15:8], rx_shift};
            end else if (byte_index == 8'd1) begin
              mem_address_next = {rx_shift, mem_address[7:0]};
            end else begin
              write_data_next = rx_shift;
            end
            byte_index_next = byte_index_inc;
            crc_byte_next   = crc_rx;
            if (byte_index_inc >= byte_count) begin
              byte_index_next = '0;
              if (step == STEP_READ_ARGS) begin
                phase_next      = PH_TX;
                step_next       = STEP_SEND_RCRC;
                shift_byte_next = crc_rx;
              end else if (step == STEP_WRITE_ARGS) begin
                phase_next      = PH_TX;
                step_next       = STEP_SEND_WCRC;
                shift_byte_next = crc_rx;
              end else begin
                phase_next = PH_IDLE;
                step_next  = STEP_NONE;
              end
            end
          end
        end
      end else if (phase == PH_TX) begin
        res.drive_zero = ~eff_shift[bit_index];
        if (bit_index != 3'd7) begin
          bit_index_next = bit_index + 3'd1;
        end else begin
          bit_index_next = '0;
          case (step)
            STEP_SEND_ROM: begin
              byte_index_next = byte_index_inc;
              if (byte_index_inc >= 8'd8 || byte_index_inc >= byte_count) begin
                phase_next      = PH_IDLE;
                step_next       = STEP_NONE;
                shift_byte_next = '0;
              end else begin
                shift_byte_next = rom_id[8*byte_index_inc[2:0] +: 8];
              end
            end
            STEP_SEND_RCRC: begin
              if ({1'b0, mem_address} < MEM_LIMIT) begin
                step_next           = STEP_SEND_DATA;
                mem_req.rd_en       = 1'b1;
                mem_req.addr        = mem_address;
                shift_from_ram_next = 1'b1;
              end else begin
                phase_next      = PH_IDLE;
                step_next       = STEP_NONE;
                shift_byte_next = '0;
              end
            end
            STEP_SEND_WCRC: begin
              if ({1'b0, mem_address} < MEM_LIMIT) begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = mem_address;
                mem_req.wdata = write_data;
              end
              phase_next      = PH_IDLE;
              step_next       = STEP_NONE;
              shift_byte_next = '0;
            end
            STEP_SEND_DATA: begin
              if (addr_inc < MEM_LIMIT) begin
                mem_address_next    = addr_inc[15:0];
                mem_req.rd_en       = 1'b1;
                mem_req.addr        = addr_inc[15:0];
                shift_from_ram_next = 1'b1;
              end else begin
                phase_next      = PH_IDLE;
                step_next       = STEP_NONE;
                shift_byte_next = '0;
              end
            end
            default: begin
              phase_next      = PH_IDLE;
              step_next       = STEP_NONE;
              shift_byte_next = '0;
            end
          endcase
        end
      end else begin
        phase_next = PH_IDLE;
      end
    end

    case (phase_next)
      PH_IDLE: res.phase = PHASE_CODE_IDLE;
      PH_RX:   res.phase = PHASE_CODE_RX;
      PH_TX:   res.phase = PHASE_CODE_TX;
      PH_CMD:  res.phase = PHASE_CODE_CMD;
      default: res.phase = PHASE_CODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      step           <= STEP_NONE;
      bit_index      <= '0;
      byte_index     <= '0;
      byte_count     <= '0;
      shift_byte     <= '0;
      shift_from_ram <= 1'b0;
      command_byte   <= '0;
      selected       <= 1'b0;
      mem_address    <= '0;
      write_data     <= '0;
      crc_byte       <= '0;
    end else begin
      phase          <= phase_next;
      step           <= step_next;
      bit_index      <= bit_index_next;
      byte_index     <= byte_index_next;
      byte_count     <= byte_count_next;
      shift_byte     <= shift_byte_next;
      shift_from_ram <= shift_from_ram_next;
      command_byte   <= command_byte_next;
      selected       <= selected_next;
      mem_address    <= mem_address_next;
      write_data     <= write_data_next;
      crc_byte       <= crc_byte_next;
    end
  end

endmodule

// ===== src/onewire_memory_slave_top.sv =====
// 1-Wire memory slave, protocol level. Each input transfer on the s_ side is one
// bus event: s_tuser low for a reset pulse, high for one time slot with the
// sampled line level in s_tdata[0]. Each input transfer produces exactly one
// output transfer on the m_ side with presence, drive_zero, the received byte
// and the protocol phase after that event.
// The user must load the rom_id register through cfg_we and cfg_data only while
// the block is idle; the block itself does not enforce this. The event is held
// in an input register, then processed into the output register when that
// register is free; m_tvalid rises once the output register holds the result.
// Throughput is one event per cycle while m_tready stays high. A memory read for
// the next transmitted byte is issued in the cycle that finishes the previous
// byte, so its data is ready for the next slot.
// After reset the data memory is loaded with its default image, one byte per
// cycle; s_tready stays low meanwhile.
// When the receiver stalls, the output register holds its transfer and the
// input register takes one more event before s_tready drops.
module onewire_memory_slave_top import owms_pkg::*; #(
  parameter int MEM_BYTES = 130
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] bus_bit, [7:1] zero
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] presence, [1] drive_zero, [2] rx_byte_valid,
                                 // [10:3] rx_byte, [12:11] phase, [15:13] zero
  input  logic        cfg_we,
  input  logic [63:0] cfg_data
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

  logic [63:0]   rom_id;
  logic          in_valid;
  logic          in_cmd;
  logic          in_bit;
  result_t       out_res;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic          out_free;
  logic          fire;
  logic          s_fire;
  result_t       res;
  mem_req_t      mem_req;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !rst && !clearing && (!in_valid || out_free);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tdata  = {3'b000, out_res};

  assign ram_we    = clearing || (fire && mem_req.wr_en);
  assign ram_waddr = clearing ? clr_addr : mem_req.addr[AW-1:0];
  assign ram_wdata = clearing ? image_byte(16'(clr_addr)) : mem_req.wdata;
  assign ram_re    = fire && mem_req.rd_en;

  owms_core #(
    .MEM_BYTES(MEM_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .cmd       (in_cmd),
    .bus_bit   (in_bit),
    .rom_id    (rom_id),
    .ram_rdata (ram_rdata),
    .mem_req   (mem_req),
    .res       (res)
  );

  owms_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mem_req.addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_id   <= ROM_ID_RESET;
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (cfg_we) begin
        rom_id <= cfg_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == CLR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (s_fire) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_cmd <= s_tuser;
      in_bit <= s_tdata[0];
    end
    if (fire) begin
      out_res <= res;
    end
  end

endmodule

// ===== src/owms_checker.sv =====
module owms_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A reset clears the output side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled transfer keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transfer changed");

  // A presence answer always leaves the slave awaiting a command.
  a_presence: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[12:11] == 2'd3 && m_tdata[2:1] == 2'b00)
    else $error("presence with wrong phase or slot result");

  // The received byte is zero unless it is flagged.
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'h00 && m_tdata[15:13] == 3'b000)
    else $error("received byte without valid flag");

  // No slot can both receive a byte and drive the line.
  a_rx_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2] && m_tdata[1]))
    else $error("slot both received and transmitted");

endmodule

bind onewire_memory_slave_top owms_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
